[rtl/assert_macros.svh]
// Assertion macros shared by the lattice matrix RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define LMC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LMC_ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lmc_pkg.sv]
// Shared types and constants of the lattice matrix unit.
// No dependencies.
`timescale 1ns / 1ps

package lmc_pkg;

	localparam int LEN_W = 24;
	localparam int ANG_W = 24;
	localparam int OUT_W = 25;
	localparam int TRIG_W = 32;
	localparam int ANGR_W = 26;
	localparam int DEG_FRAC = 16;
	localparam int CORDIC_STEPS = 22;
	localparam int TRIG_LAT = 5 + CORDIC_STEPS + 1;
	localparam int FIFO_DEPTH = 4;

	localparam logic signed [TRIG_W-1:0] ONE30 = 32'sd1073741824;
	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef struct packed {
		logic [LEN_W-1:0] len_a;
		logic [LEN_W-1:0] len_b;
		logic [LEN_W-1:0] len_c;
		logic signed [TRIG_W-1:0] cos_a;
		logic signed [TRIG_W-1:0] cos_b;
		logic signed [TRIG_W-1:0] cos_g;
		logic signed [TRIG_W-1:0] sin_g;
	} item_t;

	// arctangent of 2^-i in Q16 degrees
	function automatic logic signed [ANGR_W-1:0] atan_q16(input int i);
		logic signed [ANGR_W-1:0] v;
		case (i)
			0: v = 26'sd2949120;
			1: v = 26'sd1740967;
			2: v = 26'sd919879;
			3: v = 26'sd466945;
			4: v = 26'sd234379;
			5: v = 26'sd117304;
			6: v = 26'sd58666;
			7: v = 26'sd29335;
			8: v = 26'sd14668;
			9: v = 26'sd7334;
			10: v = 26'sd3667;
			11: v = 26'sd1833;
			12: v = 26'sd917;
			13: v = 26'sd458;
			14: v = 26'sd229;
			15: v = 26'sd115;
			16: v = 26'sd57;
			17: v = 26'sd29;
			18: v = 26'sd14;
			19: v = 26'sd7;
			20: v = 26'sd4;
			21: v = 26'sd2;
			default: v = 26'sd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/lmc_trig.sv]
// Pipelined cosine/sine of one Q8.F degree angle: reduction mod 360,
// fold to +-90, exact-angle detection and a 22-step CORDIC. Uses lmc_pkg.
`timescale 1ns / 1ps

module lmc_trig #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic [lmc_pkg::ANG_W-1:0] angle,
	output logic signed [lmc_pkg::TRIG_W-1:0] cos_val,
	output logic signed [lmc_pkg::TRIG_W-1:0] sin_val
);

	localparam int RAW_W = lmc_pkg::ANG_W + lmc_pkg::DEG_FRAC;
	localparam int T_W = RAW_W - FRAC_BITS;
	localparam int RW = lmc_pkg::ANGR_W;
	localparam int QUO_W = 8;
	localparam int XY_W = lmc_pkg::TRIG_W + 1;
	localparam int N = lmc_pkg::CORDIC_STEPS;
	localparam logic [RW-1:0] DEG360 = RW'(360 << lmc_pkg::DEG_FRAC);
	localparam logic signed [RW-1:0] DEG180 = RW'(180 << lmc_pkg::DEG_FRAC);
	localparam logic signed [RW-1:0] DEG90 = RW'(90 << lmc_pkg::DEG_FRAC);
	localparam logic [15:0] MOD_RECIP = 16'((64'd1 << 40) / 64'(360 << lmc_pkg::DEG_FRAC));

	typedef enum logic [1:0] {CLS_ROTATE, CLS_ZERO, CLS_POS90, CLS_NEG90} cls_t;

	logic [RAW_W-1:0] raw;
	logic [T_W-1:0] t_s1, t_s2;
	logic [QUO_W-1:0] quo_s2;
	logic [RW-1:0] rem_s3;
	logic [RW-1:0] red_c;
	logic signed [RW-1:0] wrap_c, ang_s4, fold_c;
	logic neg_c;
	cls_t cls_c;

	logic signed [XY_W-1:0] x_p [0:N];
	logic signed [XY_W-1:0] y_p [0:N];
	logic signed [RW-1:0] z_p [0:N];
	logic neg_p [0:N];
	cls_t cls_p [0:N];

	logic signed [lmc_pkg::TRIG_W-1:0] xc_c, yc_c, xs_c, ys_c;

	function automatic logic signed [lmc_pkg::TRIG_W-1:0] clamp_unit(
		input logic signed [XY_W-1:0] v);
		if (v > XY_W'(lmc_pkg::ONE30))
			return lmc_pkg::ONE30;
		else if (v < -XY_W'(lmc_pkg::ONE30))
			return -lmc_pkg::ONE30;
		else
			return lmc_pkg::TRIG_W'(v);
	endfunction

	assign raw = {angle, {lmc_pkg::DEG_FRAC{1'b0}}};

	// mod 360 by reciprocal; estimate is low by at most one
	always_comb begin
		red_c = (rem_s3 >= DEG360) ? rem_s3 - DEG360 : rem_s3;
		wrap_c = ($signed(red_c) > DEG180) ? $signed(red_c) - $signed(DEG360) : $signed(red_c);
	end

	always_comb begin
		fold_c = ang_s4;
		neg_c = 1'b0;
		if (ang_s4 > DEG90) begin
			fold_c = ang_s4 - DEG180;
			neg_c = 1'b1;
		end else if (ang_s4 < -DEG90) begin
			fold_c = ang_s4 + DEG180;
			neg_c = 1'b1;
		end
		if (fold_c == '0)
			cls_c = CLS_ZERO;
		else if (fold_c == DEG90)
			cls_c = CLS_POS90;
		else if (fold_c == -DEG90)
			cls_c = CLS_NEG90;
		else
			cls_c = CLS_ROTATE;
	end

	always_ff @(posedge clk) begin
		t_s1 <= T_W'(raw >> FRAC_BITS);
		t_s2 <= t_s1;
		quo_s2 <= QUO_W'((48'(t_s1) * 48'(MOD_RECIP)) >> 40);
		rem_s3 <= RW'(40'(t_s2) - 40'(quo_s2) * 40'(DEG360));
		ang_s4 <= wrap_c;
		x_p[0] <= XY_W'(lmc_pkg::CORDIC_GAIN);
		y_p[0] <= '0;
		z_p[0] <= fold_c;
		neg_p[0] <= neg_c;
		cls_p[0] <= cls_c;
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (z_p[i] >= 0) begin
				x_p[i+1] <= x_p[i] - (y_p[i] >>> i);
				y_p[i+1] <= y_p[i] + (x_p[i] >>> i);
				z_p[i+1] <= z_p[i] - lmc_pkg::atan_q16(i);
			end else begin
				x_p[i+1] <= x_p[i] + (y_p[i] >>> i);
				y_p[i+1] <= y_p[i] - (x_p[i] >>> i);
				z_p[i+1] <= z_p[i] + lmc_pkg::atan_q16(i);
			end
			neg_p[i+1] <= neg_p[i];
			cls_p[i+1] <= cls_p[i];
		end
	end

	always_comb begin
		unique case (cls_p[N])
			CLS_ZERO: begin
				xs_c = lmc_pkg::ONE30;
				ys_c = '0;
			end
			CLS_POS90: begin
				xs_c = '0;
				ys_c = lmc_pkg::ONE30;
			end
			CLS_NEG90: begin
				xs_c = '0;
				ys_c = -lmc_pkg::ONE30;
			end
			default: begin
				xs_c = clamp_unit(x_p[N]);
				ys_c = clamp_unit(y_p[N]);
			end
		endcase
		xc_c = neg_p[N] ? -xs_c : xs_c;
		yc_c = neg_p[N] ? -ys_c : ys_c;
	end

	always_ff @(posedge clk) begin
		cos_val <= xc_c;
		sin_val <= yc_c;
	end

endmodule

[rtl/lmc_front.sv]
// Front end: takes a transaction, runs the three angle pipelines and
// delays the lengths alongside. Uses lmc_pkg and lmc_trig.
`timescale 1ns / 1ps

module lmc_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  logic [lmc_pkg::LEN_W-1:0] length_a,
	input  logic [lmc_pkg::LEN_W-1:0] length_b,
	input  logic [lmc_pkg::LEN_W-1:0] length_c,
	input  logic [lmc_pkg::ANG_W-1:0] angle_alpha,
	input  logic [lmc_pkg::ANG_W-1:0] angle_beta,
	input  logic [lmc_pkg::ANG_W-1:0] angle_gamma,
	output logic out_valid,
	output lmc_pkg::item_t out_item
);

	localparam int L = lmc_pkg::TRIG_LAT;

	logic valid_q [0:L-1];
	logic [3*lmc_pkg::LEN_W-1:0] len_q [0:L-1];
	logic signed [lmc_pkg::TRIG_W-1:0] cos_a, sin_a, cos_b, sin_b, cos_g, sin_g;

	lmc_trig #(.FRAC_BITS(FRAC_BITS)) u_trig_a (
		.clk(clk), .angle(angle_alpha), .cos_val(cos_a), .sin_val(sin_a));
	lmc_trig #(.FRAC_BITS(FRAC_BITS)) u_trig_b (
		.clk(clk), .angle(angle_beta), .cos_val(cos_b), .sin_val(sin_b));
	lmc_trig #(.FRAC_BITS(FRAC_BITS)) u_trig_g (
		.clk(clk), .angle(angle_gamma), .cos_val(cos_g), .sin_val(sin_g));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L; i++)
				valid_q[i] <= 1'b0;
		end else begin
			valid_q[0] <= take;
			for (int i = 1; i < L; i++)
				valid_q[i] <= valid_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		len_q[0] <= {length_a, length_b, length_c};
		for (int i = 1; i < L; i++)
			len_q[i] <= len_q[i-1];
	end

	// sines of alpha and beta are not needed downstream
	assign out_valid = valid_q[L-1] & (sin_a[0] | ~sin_a[0]) & (sin_b[0] | ~sin_b[0]);
	assign out_item.len_a = len_q[L-1][3*lmc_pkg::LEN_W-1:2*lmc_pkg::LEN_W];
	assign out_item.len_b = len_q[L-1][2*lmc_pkg::LEN_W-1:lmc_pkg::LEN_W];
	assign out_item.len_c = len_q[L-1][lmc_pkg::LEN_W-1:0];
	assign out_item.cos_a = cos_a;
	assign out_item.cos_b = cos_b;
	assign out_item.cos_g = cos_g;
	assign out_item.sin_g = sin_g;

endmodule

[rtl/lmc_fifo.sv]
// Short queue between front and back end; drains one entry per cycle.
// Uses lmc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  lmc_pkg::item_t push_item,
	output logic full,
	output logic pop_valid,
	output lmc_pkg::item_t pop_item
);

	localparam int AW = $clog2(DEPTH);

	lmc_pkg::item_t mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0] count_q;
	logic pop;

	assign full = (count_q == (AW+1)'(DEPTH));
	assign pop = (count_q != '0);
	assign pop_valid = pop;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	`LMC_ASSERT(a_no_push_full, clk, arst_n, push |-> !full, "push into full queue")
	`LMC_ASSERT(a_count_range, clk, arst_n, count_q <= (AW+1)'(DEPTH), "queue count out of range")

endmodule

[rtl/lmc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, 40-bit quotient
// clamped to 2^39, with a sideband carried alongside. No package use.
`timescale 1ns / 1ps

module lmc_div #(
	parameter int SIDE_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [61:0] dividend,
	input  logic [30:0] divisor,
	input  logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic [39:0] quot,
	output logic [SIDE_W-1:0] side_out
);

	localparam int QB = 40;
	localparam logic [QB-1:0] QMAX = 40'd1 << 39;

	logic [61:0] rem_p [0:QB];
	logic [30:0] dm_p [0:QB];
	logic [QB-1:0] quo_p [0:QB];
	logic ovf_p [0:QB];
	logic [SIDE_W-1:0] side_p [0:QB];
	logic vld_p [0:QB];

	always_ff @(posedge clk) begin
		rem_p[0] <= dividend;
		dm_p[0] <= divisor;
		quo_p[0] <= '0;
		ovf_p[0] <= ({9'd0, dividend[61:40]} >= divisor);
		side_p[0] <= side_in;
	end

	for (genvar j = 0; j < QB; j++) begin : g_step
		logic [70:0] ext, trial;
		logic ge;
		always_comb begin
			ext = {9'd0, rem_p[j]};
			trial = 71'(dm_p[j]) << (QB - 1 - j);
			ge = (ext >= trial);
		end
		always_ff @(posedge clk) begin
			rem_p[j+1] <= ge ? 62'(ext - trial) : rem_p[j];
			quo_p[j+1] <= {quo_p[j][QB-2:0], ge};
			dm_p[j+1] <= dm_p[j];
			ovf_p[j+1] <= ovf_p[j];
			side_p[j+1] <= side_p[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QB; i++)
				vld_p[i] <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_p[0] <= in_valid;
			for (int i = 1; i <= QB; i++)
				vld_p[i] <= vld_p[i-1];
			out_valid <= vld_p[QB];
		end
	end

	always_ff @(posedge clk) begin
		quot <= (ovf_p[QB] || quo_p[QB] > QMAX) ? QMAX : quo_p[QB];
		side_out <= side_p[QB];
	end

endmodule

[rtl/lmc_isqrt.sv]
// Pipelined floor integer square root of a 61-bit value, one root bit
// per stage, with a sideband. No package use.
`timescale 1ns / 1ps

module lmc_isqrt #(
	parameter int SIDE_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [60:0] radicand,
	input  logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic [30:0] root,
	output logic [SIDE_W-1:0] side_out
);

	localparam int RB = 31;

	logic [60:0] rem_p [0:RB];
	logic [RB-1:0] res_p [0:RB];
	logic [SIDE_W-1:0] side_p [0:RB];
	logic vld_p [0:RB];

	always_ff @(posedge clk) begin
		rem_p[0] <= radicand;
		res_p[0] <= '0;
		side_p[0] <= side_in;
	end

	for (genvar j = 0; j < RB; j++) begin : g_step
		localparam int K = RB - 1 - j;
		logic [61:0] trial;
		logic ge;
		always_comb begin
			trial = (62'(res_p[j]) << (K + 1)) | (62'd1 << (2 * K));
			ge = ({1'b0, rem_p[j]} >= trial);
		end
		always_ff @(posedge clk) begin
			rem_p[j+1] <= ge ? 61'({1'b0, rem_p[j]} - trial) : rem_p[j];
			res_p[j+1] <= ge ? (res_p[j] | (RB'(1) << K)) : res_p[j];
			side_p[j+1] <= side_p[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= RB; i++)
				vld_p[i] <= 1'b0;
		end else begin
			vld_p[0] <= in_valid;
			for (int i = 1; i <= RB; i++)
				vld_p[i] <= vld_p[i-1];
		end
	end

	assign out_valid = vld_p[RB];
	assign root = res_p[RB];
	assign side_out = side_p[RB];

endmodule

[rtl/lmc_back.sv]
// Back end: products, direction term by division, root, rounding and
// saturation. Uses lmc_pkg, lmc_div, lmc_isqrt and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  lmc_pkg::item_t in_item,
	output logic done,
	output logic signed [lmc_pkg::OUT_W-1:0] vec_a_x,
	output logic signed [lmc_pkg::OUT_W-1:0] vec_b_x,
	output logic signed [lmc_pkg::OUT_W-1:0] vec_b_y,
	output logic signed [lmc_pkg::OUT_W-1:0] vec_c_x,
	output logic signed [lmc_pkg::OUT_W-1:0] vec_c_y,
	output logic signed [lmc_pkg::OUT_W-1:0] vec_c_z,
	output logic cell_invalid
);

	localparam int LW = lmc_pkg::LEN_W;
	localparam int OW = lmc_pkg::OUT_W;
	localparam int TW = lmc_pkg::TRIG_W;

	typedef struct packed {
		logic [LW-1:0] len_a;
		logic [LW-1:0] len_c;
		logic signed [OW-1:0] r1;
		logic signed [OW-1:0] r2;
		logic signed [OW-1:0] r3;
		logic bad;
		logic sgz;
		logic qneg;
		logic [60:0] cbsq;
	} div_side_t;

	typedef struct packed {
		logic [LW-1:0] len_a;
		logic [LW-1:0] len_c;
		logic signed [OW-1:0] r1;
		logic signed [OW-1:0] r2;
		logic signed [OW-1:0] r3;
		logic signed [OW-1:0] r4;
		logic bad;
		logic skip;
	} root_side_t;

	localparam int DSW = $bits(div_side_t);
	localparam int RSW = $bits(root_side_t);

	function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
		logic signed [65:0] s;
		s = p + 66'sd536870912;
		return 36'(s >>> 30);
	endfunction

	function automatic logic sat_hit(input logic signed [35:0] v);
		return (v > 36'(lmc_pkg::OUT_MAX)) || (v < 36'(lmc_pkg::OUT_MIN));
	endfunction

	function automatic logic signed [OW-1:0] sat_val(input logic signed [35:0] v);
		if (v > 36'(lmc_pkg::OUT_MAX))
			return lmc_pkg::OUT_MAX;
		else if (v < 36'(lmc_pkg::OUT_MIN))
			return lmc_pkg::OUT_MIN;
		else
			return OW'(v);
	endfunction

	// stage 1: first products
	logic valid_s1;
	logic [LW-1:0] a_s1, c_s1;
	logic signed [TW-1:0] ca_s1, sg_s1;
	logic signed [56:0] pbc_s1, pbs_s1, pcc_s1;
	logic signed [63:0] pcg_s1, cbsq_s1;
	logic signed [OW-1:0] b_se, c_se;

	assign b_se = $signed({1'b0, in_item.len_b});
	assign c_se = $signed({1'b0, in_item.len_c});

	always_ff @(posedge clk) begin
		a_s1 <= in_item.len_a;
		c_s1 <= in_item.len_c;
		ca_s1 <= in_item.cos_a;
		sg_s1 <= in_item.sin_g;
		pbc_s1 <= b_se * in_item.cos_g;
		pbs_s1 <= b_se * in_item.sin_g;
		pcc_s1 <= c_se * in_item.cos_b;
		pcg_s1 <= in_item.cos_b * in_item.cos_g;
		cbsq_s1 <= in_item.cos_b * in_item.cos_b;
	end

	// stage 2: round first results, set up the division
	logic valid_s2;
	logic [61:0] dividend_s2;
	logic [30:0] divisor_s2;
	div_side_t dside_s2, dside_c;
	logic signed [35:0] rb_x, rb_y, rc_x, p_cg, num_c;
	logic [31:0] nm_c;
	logic [30:0] dm_c;

	always_comb begin
		rb_x = rnd30(66'(pbc_s1));
		rb_y = rnd30(66'(pbs_s1));
		rc_x = rnd30(66'(pcc_s1));
		p_cg = rnd30(66'(pcg_s1));
		num_c = 36'(ca_s1) - p_cg;
		nm_c = (num_c < 0) ? 32'(-num_c) : 32'(num_c);
		dm_c = (sg_s1 < 0) ? 31'(-sg_s1) : 31'(sg_s1);
		dside_c.len_a = a_s1;
		dside_c.len_c = c_s1;
		dside_c.r1 = sat_val(rb_x);
		dside_c.r2 = sat_val(rb_y);
		dside_c.r3 = sat_val(rc_x);
		dside_c.bad = sat_hit(rb_x) | sat_hit(rb_y) | sat_hit(rc_x);
		dside_c.sgz = (sg_s1 == '0);
		dside_c.qneg = (num_c < 0) != (sg_s1 < 0);
		dside_c.cbsq = cbsq_s1[60:0];
	end

	always_ff @(posedge clk) begin
		dside_s2 <= dside_c;
		dividend_s2 <= (62'(nm_c) << 30) + 62'(dm_c >> 1);
		divisor_s2 <= dm_c;
	end

	logic div_valid;
	logic [39:0] qm_d;
	logic [DSW-1:0] dside_bits;
	div_side_t dside_d;

	lmc_div #(.SIDE_W(DSW)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s2),
		.dividend(dividend_s2), .divisor(divisor_s2), .side_in(dside_s2),
		.out_valid(div_valid), .quot(qm_d), .side_out(dside_bits));

	assign dside_d = dside_bits;

	// stage 3: products with the direction term
	logic valid_s3;
	div_side_t dside_s3;
	logic signed [40:0] q_c;
	logic signed [45:0] cqh_s3;
	logic [43:0] cql_s3;
	logic [61:0] qsq_s3;
	logic qbig_s3;
	logic signed [OW-1:0] cd_se;

	assign q_c = dside_d.qneg ? -$signed({1'b0, qm_d}) : $signed({1'b0, qm_d});
	assign cd_se = $signed({1'b0, dside_d.len_c});

	always_ff @(posedge clk) begin
		dside_s3 <= dside_d;
		cqh_s3 <= cd_se * $signed(q_c[40:20]);
		cql_s3 <= dside_d.len_c * q_c[19:0];
		qsq_s3 <= qm_d[30:0] * qm_d[30:0];
		qbig_s3 <= (qm_d > 40'(lmc_pkg::ONE30));
	end

	// stage 4: c*q, root argument
	logic valid_s4;
	root_side_t rside_s4, rside_c;
	logic [60:0] rad_s4, rad_c;
	logic signed [65:0] cq_c;
	logic signed [35:0] rq_c;
	logic signed [63:0] arg_c;
	logic argneg_c, skip_c;

	always_comb begin
		cq_c = (66'(cqh_s3) <<< 20) + $signed({22'd0, cql_s3});
		rq_c = rnd30(cq_c);
		arg_c = (64'sd1 <<< 60) - $signed({3'd0, dside_s3.cbsq}) - $signed({2'd0, qsq_s3});
		argneg_c = arg_c[63];
		skip_c = dside_s3.sgz | qbig_s3 | argneg_c;
		rad_c = skip_c ? '0 : arg_c[60:0];
		rside_c.len_a = dside_s3.len_a;
		rside_c.len_c = dside_s3.len_c;
		rside_c.r1 = dside_s3.r1;
		rside_c.r2 = dside_s3.r2;
		rside_c.r3 = dside_s3.r3;
		rside_c.r4 = dside_s3.sgz ? '0 : sat_val(rq_c);
		rside_c.bad = dside_s3.bad | dside_s3.sgz
			| (!dside_s3.sgz & (sat_hit(rq_c) | qbig_s3 | argneg_c));
		rside_c.skip = skip_c;
	end

	always_ff @(posedge clk) begin
		rside_s4 <= rside_c;
		rad_s4 <= rad_c;
	end

	logic root_valid;
	logic [30:0] root_r;
	logic [RSW-1:0] rside_bits;
	root_side_t rside_r;

	lmc_isqrt #(.SIDE_W(RSW)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s4),
		.radicand(rad_s4), .side_in(rside_s4),
		.out_valid(root_valid), .root(root_r), .side_out(rside_bits));

	assign rside_r = rside_bits;

	// stage 5: c*root
	logic valid_s5;
	root_side_t rside_s5;
	logic signed [56:0] pcr_s5;
	logic signed [OW-1:0] cr_se;
	logic signed [35:0] rz_c;

	assign cr_se = $signed({1'b0, rside_r.len_c});

	always_ff @(posedge clk) begin
		rside_s5 <= rside_r;
		pcr_s5 <= cr_se * $signed({1'b0, root_r});
	end

	assign rz_c = rnd30(66'(pcr_s5));

	// output register
	always_ff @(posedge clk) begin
		vec_a_x <= $signed({1'b0, rside_s5.len_a});
		vec_b_x <= rside_s5.r1;
		vec_b_y <= rside_s5.r2;
		vec_c_x <= rside_s5.r3;
		vec_c_y <= rside_s5.r4;
		vec_c_z <= rside_s5.skip ? '0 : sat_val(rz_c);
		cell_invalid <= rside_s5.bad | (!rside_s5.skip & sat_hit(rz_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= div_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= root_valid;
			done <= valid_s5;
		end
	end

	`LMC_ASSERT(a_cz_nonneg, clk, arst_n, done |-> !vec_c_z[OW-1], "negative c_z")
	`LMC_ASSERT_CLK(a_rst_quiet, clk, !arst_n |-> !done, "strobe during reset")

endmodule

[rtl/lattice_matrix_from_cell_unit.sv]
// Top level of the unit-cell to lattice-matrix converter.
// Uses lmc_pkg, lmc_front, lmc_fifo and lmc_back.
`timescale 1ns / 1ps

// Converts one crystal cell (lengths a, b, c in Q8.F angstroms, angles
// alpha, beta, gamma in Q8.F degrees) into the six non-zero entries of the
// lower-triangular lattice matrix in signed Q9.16. A transaction is taken
// at a clock edge with start high and busy low; one new cell can enter on
// every clock. Each result appears on the vec_* ports and cell_invalid for
// exactly one cycle, marked by done; the receiver cannot hold results off.
// On its way a cell passes the 28-stage angle pipeline (reduction plus
// 22-step CORDIC), the 40-stage bit-per-cycle divider for the c_y direction
// term and the 31-stage bit-per-cycle square root for c_z, plus the product
// stages of the back end. Results come out in the order cells went in.
// cell_invalid is set when sin gamma is zero (c_y and c_z then read zero),
// when the direction term exceeds one in magnitude or the root argument is
// negative (c_z reads zero) or when any entry saturated.

module lattice_matrix_from_cell_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [lmc_pkg::LEN_W-1:0] length_a,
	input  logic [lmc_pkg::LEN_W-1:0] length_b,
	input  logic [lmc_pkg::LEN_W-1:0] length_c,
	input  logic [lmc_pkg::ANG_W-1:0] angle_alpha,
	input  logic [lmc_pkg::ANG_W-1:0] angle_beta,
	input  logic [lmc_pkg::ANG_W-1:0] angle_gamma,
	output logic done,
	output logic signed [lmc_pkg::OUT_W-1:0] vec_a_x,
	output logic signed [lmc_pkg::OUT_W-1:0] vec_b_x,
	output logic signed [lmc_pkg::OUT_W-1:0] vec_b_y,
	output logic signed [lmc_pkg::OUT_W-1:0] vec_c_x,
	output logic signed [lmc_pkg::OUT_W-1:0] vec_c_y,
	output logic signed [lmc_pkg::OUT_W-1:0] vec_c_z,
	output logic cell_invalid
);

	logic take;
	logic front_valid;
	lmc_pkg::item_t front_item;
	logic q_full;
	logic q_valid;
	lmc_pkg::item_t q_item;

	// busy only reflects a full queue; the back end drains every cycle
	assign busy = q_full;
	assign take = start & ~busy;

	// front: angle reduction and CORDIC for all three angles in parallel
	lmc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take),
		.length_a(length_a), .length_b(length_b), .length_c(length_c),
		.angle_alpha(angle_alpha), .angle_beta(angle_beta),
		.angle_gamma(angle_gamma),
		.out_valid(front_valid), .out_item(front_item));

	// queue decoupling the two halves
	lmc_fifo #(.DEPTH(lmc_pkg::FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(front_valid), .push_item(front_item), .full(q_full),
		.pop_valid(q_valid), .pop_item(q_item));

	// back: products, division, root, rounding and saturation
	lmc_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_valid), .in_item(q_item),
		.done(done),
		.vec_a_x(vec_a_x), .vec_b_x(vec_b_x), .vec_b_y(vec_b_y),
		.vec_c_x(vec_c_x), .vec_c_y(vec_c_y), .vec_c_z(vec_c_z),
		.cell_invalid(cell_invalid));

endmodule

[tb/lattice_matrix_from_cell_unit_tb.sv]
// Self-checking testbench for the unit-cell to lattice-matrix converter.
// Depends on lmc_pkg and lattice_matrix_from_cell_unit.
`timescale 1ns / 1ps

// Bit-exact predictor of the lattice matrix plus an in-order result store.
// Each accepted cell is converted here the same way the block does it:
// angle reduction, 22-step rotation CORDIC, rounded Q30 products,
// a rounded divide for the c_y direction term and a floor square root for c_z.
class lattice_scoreboard;
	typedef struct {
		logic signed [lmc_pkg::OUT_W-1:0] v[6];
		logic flag;
	} lattice_row_t;

	lattice_row_t pending_rows[$];
	int mismatches = 0;
	int cells_seen = 0;
	int invalid_seen = 0;

	static const longint ATAN_Q16[22] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2};

	function automatic void cos_sin(input logic [23:0] raw, output longint cs,
		output longint sn);
		longint t, x, y, nx;
		bit flip;
		t = longint'(raw) % (longint'(360) << 16);
		flip = 0;
		if (t > (longint'(180) << 16)) t -= longint'(360) << 16;
		if (t > (longint'(90) << 16)) begin
			t -= longint'(180) << 16;
			flip = 1;
		end else if (t < -(longint'(90) << 16)) begin
			t += longint'(180) << 16;
			flip = 1;
		end
		if (t == 0) begin
			x = 1 << 30;
			y = 0;
		end else if (t == (longint'(90) << 16)) begin
			x = 0;
			y = 1 << 30;
		end else if (t == -(longint'(90) << 16)) begin
			x = 0;
			y = -(1 << 30);
		end else begin
			x = 652032874;
			y = 0;
			for (int i = 0; i < 22; i++) begin
				if (t >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					t -= ATAN_Q16[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					t += ATAN_Q16[i];
				end
				x = nx;
			end
			if (x > (1 << 30)) x = 1 << 30;
			if (x < -(1 << 30)) x = -(1 << 30);
			if (y > (1 << 30)) y = 1 << 30;
			if (y < -(1 << 30)) y = -(1 << 30);
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endfunction

	function automatic longint round_q30(input longint x, input longint f);
		return (x * f + (longint'(1) << 29)) >>> 30;
	endfunction

	function automatic longint saturate(input longint v, inout logic flag);
		if (v > 16777215) begin
			flag = 1;
			return 16777215;
		end
		if (v < -16777216) begin
			flag = 1;
			return -16777216;
		end
		return v;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function void note_cell(input logic [23:0] la, lb, lc, aa, ab, ag);
		longint ca, sa, cb, sb, cg, sg, num, q, arg;
		longint unsigned nm, dm, qm;
		longint r[6];
		lattice_row_t row;
		row.flag = 0;
		cos_sin(aa, ca, sa);
		cos_sin(ab, cb, sb);
		cos_sin(ag, cg, sg);
		r[0] = saturate(longint'(la), row.flag);
		r[1] = saturate(round_q30(longint'(lb), cg), row.flag);
		r[2] = saturate(round_q30(longint'(lb), sg), row.flag);
		r[3] = saturate(round_q30(longint'(lc), cb), row.flag);
		r[4] = 0;
		r[5] = 0;
		if (sg == 0) begin
			row.flag = 1;
		end else begin
			num = ca - round_q30(cb, cg);
			nm = num < 0 ? -num : num;
			dm = sg < 0 ? -sg : sg;
			qm = ((nm << 30) + (dm >> 1)) / dm;
			if (qm > (64'd1 << 39)) qm = 64'd1 << 39;
			q = ((num < 0) != (sg < 0)) ? -longint'(qm) : longint'(qm);
			r[4] = saturate(round_q30(longint'(lc), q), row.flag);
			if (qm > (64'd1 << 30)) begin
				row.flag = 1;
			end else begin
				arg = (longint'(1) << 60) - cb * cb - q * q;
				if (arg < 0) row.flag = 1;
				else r[5] = saturate(round_q30(longint'(lc),
					longint'(floor_sqrt(arg))), row.flag);
			end
		end
		for (int j = 0; j < 6; j++) row.v[j] = r[j][24:0];
		pending_rows.push_back(row);
		cells_seen++;
		if (row.flag) invalid_seen++;
	endfunction

	function void check_result(input logic signed [24:0] got[6], input logic got_flag);
		lattice_row_t row;
		string names[6] = '{"vec_a_x", "vec_b_x", "vec_b_y", "vec_c_x",
			"vec_c_y", "vec_c_z"};
		if (pending_rows.size() == 0) begin
			$error("result strobe with no cell outstanding");
			mismatches++;
			return;
		end
		row = pending_rows.pop_front();
		for (int j = 0; j < 6; j++)
			if (got[j] !== row.v[j]) begin
				$error("%s expected %0d actual %0d", names[j], row.v[j], got[j]);
				mismatches++;
			end
		if (got_flag !== row.flag) begin
			$error("cell_invalid expected %0d actual %0d", row.flag, got_flag);
			mismatches++;
		end
	endfunction
endclass

module lattice_matrix_from_cell_unit_tb;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 200;
	localparam int RANDOM_CELLS = 450;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [23:0] length_a, length_b, length_c;
	logic [23:0] angle_alpha, angle_beta, angle_gamma;
	logic done;
	logic signed [24:0] vec_a_x, vec_b_x, vec_b_y, vec_c_x, vec_c_y, vec_c_z;
	logic cell_invalid;

	lattice_scoreboard lattice_sb;
	int idle_cycles;

	lattice_matrix_from_cell_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.length_a(length_a), .length_b(length_b), .length_c(length_c),
		.angle_alpha(angle_alpha), .angle_beta(angle_beta),
		.angle_gamma(angle_gamma), .done(done),
		.vec_a_x(vec_a_x), .vec_b_x(vec_b_x), .vec_b_y(vec_b_y),
		.vec_c_x(vec_c_x), .vec_c_y(vec_c_y), .vec_c_z(vec_c_z),
		.cell_invalid(cell_invalid)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Everything below samples at the rising edge, so it sees the values
	// the block sees; inputs change at an edge only through nonblocking writes.
	always @(posedge clk) begin
		logic signed [24:0] got[6];
		if (arst_n) begin
			if (done) begin
				got = '{vec_a_x, vec_b_x, vec_b_y, vec_c_x, vec_c_y, vec_c_z};
				lattice_sb.check_result(got, cell_invalid);
			end
			if (start && !busy)
				lattice_sb.note_cell(length_a, length_b, length_c,
					angle_alpha, angle_beta, angle_gamma);
			// Watchdog: count cycles where no transaction moves either way.
			if (done || (start && !busy)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired with %0d results outstanding",
					lattice_sb.pending_rows.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Present one cell and hold it until the block takes it. start stays high
	// on return so back-to-back transactions need no re-raise.
	task automatic send_cell(input logic [23:0] la, lb, lc, aa, ab, ag);
		start <= 1'b1;
		length_a <= la;
		length_b <= lb;
		length_c <= lc;
		angle_alpha <= aa;
		angle_beta <= ab;
		angle_gamma <= ag;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (lattice_sb.pending_rows.size() != 0) @(posedge clk);
	endtask

	function automatic logic [23:0] deg(input int d);
		return 24'(d) << 16;
	endfunction

	// Mostly plausible cells (lengths 1..60 A, angles 50..130 deg) so the
	// root branch is exercised with real values; the rest is raw noise.
	task automatic send_random_cell();
		if ($urandom_range(0, 99) < 75)
			send_cell(24'($urandom_range(1 << 16, 60 << 16)),
				24'($urandom_range(1 << 16, 60 << 16)),
				24'($urandom_range(1 << 16, 60 << 16)),
				24'($urandom_range(50 << 16, 130 << 16)),
				24'($urandom_range(50 << 16, 130 << 16)),
				24'($urandom_range(50 << 16, 130 << 16)));
		else
			send_cell(24'($urandom), 24'($urandom), 24'($urandom),
				24'($urandom), 24'($urandom), 24'($urandom));
	endtask

	initial begin
		int sent;
		int burst;
		lattice_sb = new();
		idle_cycles = 0;
		arst_n = 1'b1;
		start = 1'b0;
		length_a = '0;
		length_b = '0;
		length_c = '0;
		angle_alpha = '0;
		angle_beta = '0;
		angle_gamma = '0;
		#1 arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cells: cubic, zero and full-scale lengths, exact quadrant
		// angles, sin gamma zero at 0 and 180, negative root argument,
		// saturated c_y from a tiny gamma, angles past 180.
		send_cell(deg(5), deg(5), deg(5), deg(90), deg(90), deg(90));
		send_cell(24'd0, 24'd0, 24'd0, deg(90), deg(90), deg(90));
		send_cell(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, deg(90), deg(90), deg(90));
		send_cell(deg(3), deg(4), deg(5), deg(90), deg(90), 24'd0);
		send_cell(deg(3), deg(4), deg(5), deg(90), deg(90), deg(180));
		send_cell(deg(3), deg(4), deg(5), 24'd0, 24'd0, deg(90));
		send_cell(deg(3), deg(4), deg(5), deg(180), 24'd0, deg(90));
		send_cell(deg(3), deg(4), 24'hFFFFFF, deg(90), deg(45), 24'd1);
		send_cell(deg(3), deg(4), 24'hFFFFFF, 24'd0, deg(180), 24'd1);
		send_cell(deg(7), deg(7), deg(7), deg(60), deg(60), deg(60));
		send_cell(deg(7), deg(7), deg(7), deg(120), deg(120), deg(120));
		send_cell(deg(2), deg(9), deg(11), deg(270), deg(200), deg(250));
		send_cell(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_cell(deg(6), deg(6), deg(9), deg(90), deg(90), deg(120));
		send_cell(24'h000001, 24'h000001, 24'h000001, 24'h000001, 24'h000001, 24'h000001);
		send_cell(deg(10), deg(10), deg(10), deg(100), deg(80), deg(180) + 24'd1);
		send_cell(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
		drain_results();

		sent = 0;
		while (sent < RANDOM_CELLS) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst && sent < RANDOM_CELLS; i++) begin
				send_random_cell();
				sent++;
			end
			if (sent >= RANDOM_CELLS / 2 && sent - burst < RANDOM_CELLS / 2)
				drain_results();
			else if ($urandom_range(0, 3) != 0)
				idle_for($urandom_range(1, 15));
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d cells, %0d of them flagged invalid",
			lattice_sb.cells_seen, lattice_sb.invalid_seen);
		if (lattice_sb.mismatches == 0 && lattice_sb.pending_rows.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

[lattice_matrix_from_cell_unit.f]
+incdir+rtl
rtl/lmc_pkg.sv
rtl/lmc_trig.sv
rtl/lmc_front.sv
rtl/lmc_fifo.sv
rtl/lmc_div.sv
rtl/lmc_isqrt.sv
rtl/lmc_back.sv
rtl/lattice_matrix_from_cell_unit.sv
tb/lattice_matrix_from_cell_unit_tb.sv
